@@ rtl/assert_macros.svh @@
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the executor RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is high
`define MMIE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by a consequence in the next
`define MMIE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mmie_pkg.sv @@
// ============================================================================
// mmie_pkg
// Types, opcodes and helpers shared by the memory-to-memory executor.
// ============================================================================
package mmie_pkg;

   // Data memory geometry
   localparam int MEM_WORDS = 512;
   localparam int WORD_BITS = 32;
   localparam int ADDR_BITS = $clog2(MEM_WORDS);
   localparam int OUT_BITS  = 32;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [OUT_BITS-1:0]  out_type;

   // The top word of the data memory holds the program counter
   localparam addr_type PC_ADDR = addr_type'(MEM_WORDS - 1);

   // Opcodes
   localparam logic [7:0] OP_NOP  = 8'd0;
   localparam logic [7:0] OP_MOV  = 8'd1;
   localparam logic [7:0] OP_ADD  = 8'd2;
   localparam logic [7:0] OP_SUB  = 8'd3;
   localparam logic [7:0] OP_NOT  = 8'd4;
   localparam logic [7:0] OP_OR   = 8'd5;
   localparam logic [7:0] OP_AND  = 8'd6;
   localparam logic [7:0] OP_XOR  = 8'd7;
   localparam logic [7:0] OP_RET  = 8'd8;
   localparam logic [7:0] OP_LD   = 8'd9;
   localparam logic [7:0] OP_JMP  = 8'd10;
   localparam logic [7:0] OP_JNZF = 8'd11;
   localparam logic [7:0] OP_JZF  = 8'd12;
   localparam logic [7:0] OP_SAY  = 8'd13;
   localparam logic [7:0] OP_HLT  = 8'd14;
   localparam logic [7:0] OP_JNZB = 8'd15;
   localparam logic [7:0] OP_JZB  = 8'd16;
   localparam logic [7:0] OP_LAST = OP_JZB;

   // RET prints only with this operand
   localparam word_type RET_KEY = word_type'(80);

   // Print kinds
   localparam logic [1:0] PK_NONE = 2'd0;
   localparam logic [1:0] PK_SAY  = 2'd1;
   localparam logic [1:0] PK_RET  = 2'd2;

   // Requests from the sequencer to the data memory
   typedef struct packed {
      addr_type rd_a_addr;
      addr_type rd_b_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
      logic     pc_wr;
      word_type pc_data;
   } dmem_req_type;

   // Registered read data; the pc flags mark reads of the program counter
   typedef struct packed {
      word_type rd_a_data;
      logic     rd_a_pc;
      word_type rd_b_data;
      logic     rd_b_pc;
      word_type pc;
   } dmem_rsp_type;

   // Low OUT_BITS of a word, zero extended when the word is narrower
   function automatic out_type to_out(input word_type w);
      logic [WORD_BITS+OUT_BITS-1:0] ext;
      ext = {{OUT_BITS{1'b0}}, w};
      return ext[OUT_BITS-1:0];
   endfunction

endpackage

@@ rtl/mmie_dmem.sv @@
// ============================================================================
// mmie_dmem
// Data memory with two registered read ports, one write port and the
// program counter word held in a register of its own.
// ============================================================================
module mmie_dmem
   import mmie_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dmem_req_type dm_req,
   output dmem_rsp_type dm_rsp
);

   word_type mem_ff [MEM_WORDS];
   word_type rd_a_ff;
   word_type rd_b_ff;
   logic     hit_a_ff;
   logic     hit_b_ff;
   word_type pc_ff;

   // Write port and two registered read ports
   always_ff @(posedge clock) begin
      if (dm_req.wr_en) begin
         mem_ff[dm_req.wr_addr] <= dm_req.wr_data;
      end
      rd_a_ff  <= mem_ff[dm_req.rd_a_addr];
      rd_b_ff  <= mem_ff[dm_req.rd_b_addr];
      hit_a_ff <= (dm_req.rd_a_addr == PC_ADDR);
      hit_b_ff <= (dm_req.rd_b_addr == PC_ADDR);
   end

   // Hold the program counter word
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (dm_req.pc_wr) begin
         pc_ff <= dm_req.pc_data;
      end
   end

   assign dm_rsp.rd_a_data = rd_a_ff;
   assign dm_rsp.rd_a_pc   = hit_a_ff;
   assign dm_rsp.rd_b_data = rd_b_ff;
   assign dm_rsp.rd_b_pc   = hit_b_ff;
   assign dm_rsp.pc        = pc_ff;

endmodule

@@ rtl/mem_to_mem_instruction_executor_core.sv @@
// ============================================================================
// mem_to_mem_instruction_executor_core
// Executes one instruction per transfer against a word-wide data memory
// whose top word is the program counter, and returns one result each.
// ============================================================================
// After reset the block clears all 512 words of its data memory, one
// word a cycle, and takes no instruction until that is done. An
// instruction then goes through three steps of the memory: a registered
// read of both indirect operands, a registered read of the two operand
// words, and an execute step that writes the result back and loads the
// output register. A one-entry input buffer takes the next instruction
// while one is executing, and the output register holds a result until
// it is taken.
// ============================================================================
`include "assert_macros.svh"

module mem_to_mem_instruction_executor_core
   import mmie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_cmd,
   input  logic [7:0]  req_props,
   input  logic [7:0]  req_left_operand,
   input  logic [7:0]  req_right_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_halted,
   output logic [1:0]  rsp_print_kind,
   output logic [31:0] rsp_print_value,
   output logic        rsp_bad_opcode
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_OPND  = 2'd2;
   localparam logic [1:0] ST_EXEC  = 2'd3;

   logic [1:0]   state_ff, state_in;
   addr_type     clr_cnt_ff;

   logic         buf_valid_ff;
   logic [7:0]   buf_cmd_ff, buf_props_ff, buf_left_ff, buf_right_ff;

   logic [7:0]   op_ff, left_ff, right_ff;
   logic         dst_ind_ff, src_ind_ff;
   word_type     dst_ff, src_ff;

   logic         rsp_valid_ff;
   out_type      rsp_next_pc_ff, rsp_print_value_ff;
   logic         rsp_halted_ff, rsp_bad_ff;
   logic [1:0]   rsp_kind_ff;

   dmem_req_type dm_req;
   dmem_rsp_type dm_rsp;

   logic         take, commit, accept;
   word_type     ind_a, ind_b, dst_word, src_word;
   word_type     pc, pc_inc, pc_view, opa, opb, alu, br_pc, pc_new, pval;
   logic         cond_br, wr_op, bad;
   logic [1:0]   kind;

   mmie_dmem u_dmem (
      .clock  (clock),
      .reset  (reset),
      .dm_req (dm_req),
      .dm_rsp (dm_rsp)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = !buf_valid_ff && (state_ff != ST_CLEAR);
   assign take      = (state_ff == ST_IDLE) && buf_valid_ff;
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // Resolve indirect operands; these reads see the program counter before the step
   assign ind_a    = dm_rsp.rd_a_pc ? dm_rsp.pc : dm_rsp.rd_a_data;
   assign ind_b    = dm_rsp.rd_b_pc ? dm_rsp.pc : dm_rsp.rd_b_data;
   assign dst_word = dst_ind_ff ? ind_a : word_type'(left_ff);
   assign src_word = src_ind_ff ? ind_b : word_type'(right_ff);

   // Operand words; conditional branches read before the counter moves
   assign pc      = dm_rsp.pc;
   assign pc_inc  = pc + word_type'(1);
   assign cond_br = (op_ff == OP_JNZF) || (op_ff == OP_JZF) ||
                    (op_ff == OP_JNZB) || (op_ff == OP_JZB);
   assign pc_view = cond_br ? pc : pc_inc;
   assign opa     = dm_rsp.rd_a_pc ? pc_view : dm_rsp.rd_a_data;
   assign opb     = dm_rsp.rd_b_pc ? pc_view : dm_rsp.rd_b_data;

   // Decode and execute
   always_comb begin
      alu   = '0;
      wr_op = 1'b0;
      br_pc = pc_inc;
      kind  = PK_NONE;
      pval  = '0;
      bad   = 1'b0;
      unique case (op_ff)
         OP_NOP: begin
         end
         OP_MOV: begin
            alu   = opb;
            wr_op = 1'b1;
         end
         OP_ADD: begin
            alu   = opa + opb;
            wr_op = 1'b1;
         end
         OP_SUB: begin
            alu   = opa - opb;
            wr_op = 1'b1;
         end
         OP_NOT: begin
            alu   = ~opa;
            wr_op = 1'b1;
         end
         OP_OR: begin
            alu   = opa | opb;
            wr_op = 1'b1;
         end
         OP_AND: begin
            alu   = opa & opb;
            wr_op = 1'b1;
         end
         OP_XOR: begin
            alu   = opa ^ opb;
            wr_op = 1'b1;
         end
         OP_RET: begin
            if (dst_ff == RET_KEY) begin
               kind = PK_RET;
               pval = opb;
            end
         end
         OP_LD: begin
            alu   = src_ff;
            wr_op = 1'b1;
         end
         OP_JMP: begin
            br_pc = pc + dst_ff;
         end
         OP_JNZF: begin
            br_pc = (opa != '0) ? pc + src_ff : pc_inc;
         end
         OP_JZF: begin
            br_pc = (opa == '0) ? pc + src_ff : pc_inc;
         end
         OP_SAY: begin
            kind = PK_SAY;
            pval = opa;
         end
         OP_HLT: begin
            br_pc = '1;
         end
         OP_JNZB: begin
            br_pc = (opa != '0) ? pc - src_ff : pc_inc;
         end
         OP_JZB: begin
            br_pc = (opa == '0) ? pc - src_ff : pc_inc;
         end
         default: begin
            br_pc = pc;
            bad   = 1'b1;
         end
      endcase
   end

   // A write to the top word replaces the counter
   assign pc_new = (wr_op && (dst_ff[ADDR_BITS-1:0] == PC_ADDR)) ? alu : br_pc;

   // Drive memory reads, write-back and the counter update
   always_comb begin
      dm_req           = '0;
      dm_req.rd_a_addr = addr_type'(buf_left_ff);
      dm_req.rd_b_addr = addr_type'(buf_right_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            dm_req.wr_en   = 1'b1;
            dm_req.wr_addr = clr_cnt_ff;
         end
         ST_IDLE: begin
         end
         ST_OPND: begin
            dm_req.rd_a_addr = dst_word[ADDR_BITS-1:0];
            dm_req.rd_b_addr = (op_ff == OP_RET) ? '0 : src_word[ADDR_BITS-1:0];
         end
         ST_EXEC: begin
            // keep reading the operand words while the result waits
            dm_req.rd_a_addr = dst_ff[ADDR_BITS-1:0];
            dm_req.rd_b_addr = (op_ff == OP_RET) ? '0 : src_ff[ADDR_BITS-1:0];
            dm_req.wr_en   = commit && wr_op;
            dm_req.wr_addr = dst_ff[ADDR_BITS-1:0];
            dm_req.wr_data = alu;
            dm_req.pc_wr   = commit && !bad;
            dm_req.pc_data = pc_new;
         end
         default: begin
         end
      endcase
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == '1) state_in = ST_IDLE;
         ST_IDLE:  if (take) state_in = ST_OPND;
         ST_OPND:  state_in = ST_EXEC;
         ST_EXEC:  if (commit) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + addr_type'(1);
         end
         if (accept) begin
            buf_valid_ff <= 1'b1;
         end else if (take) begin
            buf_valid_ff <= 1'b0;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the buffered transfer, the working instruction and the result
   always_ff @(posedge clock) begin
      if (accept) begin
         buf_cmd_ff   <= req_cmd;
         buf_props_ff <= req_props;
         buf_left_ff  <= req_left_operand;
         buf_right_ff <= req_right_operand;
      end
      if (take) begin
         op_ff      <= buf_cmd_ff;
         dst_ind_ff <= (buf_props_ff[7:4] != 4'd0);
         src_ind_ff <= (buf_props_ff[3:0] != 4'd0);
         left_ff    <= buf_left_ff;
         right_ff   <= buf_right_ff;
      end
      if (state_ff == ST_OPND) begin
         dst_ff <= dst_word;
         src_ff <= src_word;
      end
      if (commit) begin
         rsp_next_pc_ff     <= to_out(pc_new);
         rsp_halted_ff      <= (pc_new == '1);
         rsp_kind_ff        <= kind;
         rsp_print_value_ff <= to_out(pval);
         rsp_bad_ff         <= bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_halted      = rsp_halted_ff;
   assign rsp_print_kind  = rsp_kind_ff;
   assign rsp_print_value = rsp_print_value_ff;
   assign rsp_bad_opcode  = rsp_bad_ff;

   `MMIE_ASSERT(a_clear_blocks_input, (state_ff == ST_CLEAR) |-> !req_ready, "transfer open during clear")
   `MMIE_ASSERT_NEXT(a_take_frees_buffer, take, (state_ff == ST_OPND) && !buf_valid_ff, "take did not free buffer")
   `MMIE_ASSERT_NEXT(a_commit_loads_result, commit, (state_ff == ST_IDLE) && rsp_valid_ff, "commit lost")
   `MMIE_ASSERT(a_write_phase, dm_req.wr_en |-> ((state_ff == ST_EXEC) || (state_ff == ST_CLEAR)), "stray memory write")

endmodule

@@ test/mmie_checker.sv @@
// ============================================================================
// mmie_checker
// Shadow model and result scoreboard for the memory-to-memory executor.
// ============================================================================
// Keeps a private copy of the data memory, program counter word included,
// and executes every accepted instruction against it. The result that each
// instruction should produce is queued in order; every result transfer is
// compared field by field with the oldest queued result.
// ============================================================================
module mmie_checker
   import mmie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_cmd,
   input  logic [7:0]  req_props,
   input  logic [7:0]  req_left_operand,
   input  logic [7:0]  req_right_operand,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_next_pc,
   input  logic        rsp_halted,
   input  logic [1:0]  rsp_print_kind,
   input  logic [31:0] rsp_print_value,
   input  logic        rsp_bad_opcode,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic [1:0]  print_kind;
      logic [31:0] print_value;
      logic        bad_opcode;
   } step_result_t;

   word_type     shadow_mem [MEM_WORDS];
   step_result_t outstanding_q [$];
   int           mismatches = 0;

   assign fail_count = mismatches;

   // Execute one instruction on the shadow memory and return its result
   function automatic step_result_t execute_instr(input logic [7:0] cmd, input logic [7:0] props,
                                                  input logic [7:0] lop, input logic [7:0] rop);
      word_type     dst_w;
      word_type     src_w;
      word_type     pc_w;
      addr_type     dst_a;
      addr_type     src_a;
      logic         taken;
      step_result_t res;
      res   = '0;
      dst_w = word_type'(lop);
      src_w = word_type'(rop);
      // both indirections see memory before the step, old PC included
      if (props[3:0] != 4'd0) src_w = shadow_mem[src_w[ADDR_BITS-1:0]];
      if (props[7:4] != 4'd0) dst_w = shadow_mem[dst_w[ADDR_BITS-1:0]];
      dst_a = dst_w[ADDR_BITS-1:0];
      src_a = src_w[ADDR_BITS-1:0];
      if (cmd > OP_LAST) begin
         res.bad_opcode = 1'b1;
      end else begin
         case (cmd)
            OP_HLT: begin
               shadow_mem[PC_ADDR] = '1;
            end
            OP_JMP: begin
               shadow_mem[PC_ADDR] = shadow_mem[PC_ADDR] + dst_w;
            end
            OP_JNZF, OP_JZF, OP_JNZB, OP_JZB: begin
               taken = (shadow_mem[dst_a] != '0) == (cmd == OP_JNZF || cmd == OP_JNZB);
               if (!taken)
                  shadow_mem[PC_ADDR] = shadow_mem[PC_ADDR] + word_type'(1);
               else if (cmd == OP_JNZF || cmd == OP_JZF)
                  shadow_mem[PC_ADDR] = shadow_mem[PC_ADDR] + src_w;
               else
                  shadow_mem[PC_ADDR] = shadow_mem[PC_ADDR] - src_w;
            end
            default: begin
               // advance the PC first, so accesses to its word see the new value
               shadow_mem[PC_ADDR] = shadow_mem[PC_ADDR] + word_type'(1);
               case (cmd)
                  OP_MOV: shadow_mem[dst_a] = shadow_mem[src_a];
                  OP_ADD: shadow_mem[dst_a] = shadow_mem[dst_a] + shadow_mem[src_a];
                  OP_SUB: shadow_mem[dst_a] = shadow_mem[dst_a] - shadow_mem[src_a];
                  OP_NOT: shadow_mem[dst_a] = ~shadow_mem[dst_a];
                  OP_OR:  shadow_mem[dst_a] = shadow_mem[dst_a] | shadow_mem[src_a];
                  OP_AND: shadow_mem[dst_a] = shadow_mem[dst_a] & shadow_mem[src_a];
                  OP_XOR: shadow_mem[dst_a] = shadow_mem[dst_a] ^ shadow_mem[src_a];
                  OP_LD:  shadow_mem[dst_a] = src_w;
                  OP_RET: begin
                     if (dst_w == RET_KEY) begin
                        res.print_kind  = PK_RET;
                        res.print_value = 32'(shadow_mem[0]);
                     end
                  end
                  OP_SAY: begin
                     res.print_kind  = PK_SAY;
                     res.print_value = 32'(shadow_mem[dst_a]);
                  end
                  default: ;
               endcase
            end
         endcase
      end
      pc_w        = shadow_mem[PC_ADDR];
      res.next_pc = 32'(pc_w);
      res.halted  = (pc_w == '1);
      return res;
   endfunction

   // Count a wrong field and report the first few
   task automatic compare_field(input string field, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] rsp_%s mismatch: expected %h, got %h", $time, field, want_v, got_v);
      end
   endtask

   // Watch both channels; compare before predicting, as a result never
   // belongs to an instruction accepted at the same edge
   always @(posedge clock) begin : watch
      step_result_t got;
      step_result_t want;
      if (reset) begin
         foreach (shadow_mem[i]) shadow_mem[i] = '0;
         outstanding_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_next_pc, rsp_halted, rsp_print_kind, rsp_print_value, rsp_bad_opcode};
            if (outstanding_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] result transfer with no instruction outstanding: %h",
                           $time, got);
            end else begin
               want = outstanding_q.pop_front();
               compare_field("next_pc", want.next_pc, got.next_pc);
               compare_field("halted", 32'(want.halted), 32'(got.halted));
               compare_field("print_kind", 32'(want.print_kind), 32'(got.print_kind));
               compare_field("print_value", want.print_value, got.print_value);
               compare_field("bad_opcode", 32'(want.bad_opcode), 32'(got.bad_opcode));
            end
         end
         if (req_valid && req_ready)
            outstanding_q.push_back(execute_instr(req_cmd, req_props, req_left_operand,
                                                  req_right_operand));
      end
      pending <= outstanding_q.size();
   end

endmodule

@@ test/testbench.sv @@
// ============================================================================
// testbench
// Stimulus and verdict for the memory-to-memory instruction executor.
// ============================================================================
// Sends a directed run that touches every opcode, indirection through the
// program counter word, halt and counter wrap, then random instructions in
// phases of differing sender gaps and receiver stalls. A separate checker
// predicts and compares every result transfer.
// ============================================================================
module testbench;
   import mmie_pkg::*;

   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS      = 265;
   localparam int DRAIN_CYCLES     = 20;

   // Operand indirection selects
   localparam logic [7:0] PR_NONE  = 8'h00;
   localparam logic [7:0] PR_RIGHT = 8'h01;
   localparam logic [7:0] PR_LEFT  = 8'h10;
   localparam logic [7:0] PR_BOTH  = 8'hFF;

   // Opcodes outside the instruction set
   localparam logic [7:0] OP_UNKNOWN_LO = OP_LAST + 8'd1;
   localparam logic [7:0] OP_UNKNOWN_HI = 8'hFF;

   localparam logic [7:0] RET_OPERAND = 8'(RET_KEY);

   logic        clock;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [7:0]  req_cmd           = '0;
   logic [7:0]  req_props         = '0;
   logic [7:0]  req_left_operand  = '0;
   logic [7:0]  req_right_operand = '0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_halted;
   logic [1:0]  rsp_print_kind;
   logic [31:0] rsp_print_value;
   logic        rsp_bad_opcode;

   int fail_count;
   int pending;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit long_hold      = 1'b0;

   mem_to_mem_instruction_executor_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_props         (req_props),
      .req_left_operand  (req_left_operand),
      .req_right_operand (req_right_operand),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_halted        (rsp_halted),
      .rsp_print_kind    (rsp_print_kind),
      .rsp_print_value   (rsp_print_value),
      .rsp_bad_opcode    (rsp_bad_opcode)
   );

   mmie_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_props         (req_props),
      .req_left_operand  (req_left_operand),
      .req_right_operand (req_right_operand),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_halted        (rsp_halted),
      .rsp_print_kind    (rsp_print_kind),
      .rsp_print_value   (rsp_print_value),
      .rsp_bad_opcode    (rsp_bad_opcode),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // Offer one instruction and hold it until the transfer; returns at that edge
   task automatic send_instr(input logic [7:0] cmd, input logic [7:0] props,
                             input logic [7:0] lop, input logic [7:0] rop);
      while (chance(send_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_props         <= props;
      req_left_operand  <= lop;
      req_right_operand <= rop;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Favour a few low addresses so that instructions work on shared words
   function automatic logic [7:0] pick_operand();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      return 8'($urandom_range(0, 15));
      else if (pick < 52) return RET_OPERAND;
      else if (pick < 57) return 8'hFF;
      else                return 8'($urandom);
   endfunction

   task automatic send_random();
      logic [7:0] cmd;
      logic [7:0] props;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) cmd = 8'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
      else          cmd = 8'($urandom_range(OP_NOP, OP_LAST));
      pick = $urandom_range(0, 99);
      if (pick < 35)      props = PR_NONE;
      else if (pick < 55) props = {4'h0, 4'($urandom_range(1, 15))};
      else if (pick < 75) props = {4'($urandom_range(1, 15)), 4'h0};
      else                props = 8'($urandom);
      send_instr(cmd, props, pick_operand(), pick_operand());
   endtask

   // Receiver: random stalls, plus one long hold-off counted here
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !chance(recv_stall_pct);
         end
      end
   end

   // End the run after a long stretch with no transfer on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench failed");
      $finish;
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed run: every opcode, extremes, indirection and halt
      send_instr(OP_LD,   PR_NONE,  8'd0,        8'd255);
      send_instr(OP_LD,   PR_NONE,  8'd1,        8'd7);
      send_instr(OP_MOV,  PR_NONE,  8'd2,        8'd0);
      send_instr(OP_ADD,  PR_NONE,  8'd2,        8'd1);
      send_instr(OP_SUB,  PR_NONE,  8'd3,        8'd0);
      send_instr(OP_NOT,  PR_NONE,  8'd4,        8'd0);
      send_instr(OP_OR,   PR_NONE,  8'd5,        8'd2);
      send_instr(OP_AND,  PR_NONE,  8'd5,        8'd1);
      send_instr(OP_XOR,  PR_NONE,  8'd5,        8'd3);
      send_instr(OP_RET,  PR_NONE,  RET_OPERAND, 8'd0);
      send_instr(OP_RET,  PR_NONE,  8'd81,       8'd0);
      send_instr(OP_SAY,  PR_NONE,  8'd3,        8'd0);
      // word 4 is all ones, so it points at the program counter word
      send_instr(OP_SAY,  PR_LEFT,  8'd4,        8'd0);
      send_instr(OP_MOV,  PR_RIGHT, 8'd6,        8'd4);
      send_instr(OP_ADD,  PR_LEFT,  8'd4,        8'd1);
      send_instr(OP_LD,   PR_BOTH,  8'd1,        8'd1);
      send_instr(OP_JMP,  PR_NONE,  8'd255,      8'd0);
      send_instr(OP_JNZF, PR_NONE,  8'd0,        8'd5);
      send_instr(OP_JZF,  PR_NONE,  8'd9,        8'd200);
      send_instr(OP_JNZF, PR_NONE,  8'd9,        8'd5);
      send_instr(OP_JZF,  PR_NONE,  8'd0,        8'd5);
      send_instr(OP_JNZB, PR_NONE,  8'd0,        8'd3);
      send_instr(OP_JZB,  PR_NONE,  8'd9,        8'd255);
      send_instr(OP_HLT,  PR_NONE,  8'd0,        8'd0);
      send_instr(OP_NOP,  PR_NONE,  8'd0,        8'd0);
      send_instr(OP_UNKNOWN_LO, PR_NONE, 8'd2,   8'd1);
      send_instr(OP_UNKNOWN_HI, PR_BOTH, 8'hFF,  8'hFF);

      // Random phases of differing gap and stall rates
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               long_hold      = 1'b1;
            end
            1: begin
               send_idle_pct  = 59;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 59;
            end
            default: begin
               send_idle_pct  = 18;
               recv_stall_pct = 18;
            end
         endcase
         repeat (PHASE_ITEMS) send_random();
         // after phase 1, let the block run dry before the next phase starts
         if (phase == 1) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
      end

      // Drain and give the verdict
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
